### src/sfd_pkg.sv
// Package for the scan frame deframer: shared types, codes and fixed constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sfd_pkg;

  // Fixed framing constants.
  localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0] LAST_MARK     = 8'hFF;
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned HOLD_DEPTH   = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_HEADER_BYTE = 3'd0,
    CFG_ESCAPE_BYTE = 3'd1,
    CFG_OK_CODE     = 3'd2,
    CFG_ABORT_CODE  = 3'd3,
    CFG_MAX_POINTS  = 3'd4
  } cfg_index_e;

  // Configuration reset values.
  localparam logic [7:0]  RST_HEADER_BYTE = 8'hAA;
  localparam logic [7:0]  RST_ESCAPE_BYTE = 8'hAE;
  localparam logic [7:0]  RST_OK_CODE     = 8'hA5;
  localparam logic [7:0]  RST_ABORT_CODE  = 8'h5A;
  localparam logic [23:0] RST_MAX_POINTS  = 24'd2000;

  // Deframer modes.
  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_DONE   = 2'd3
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_POINT     = 2'd0,
    KIND_SCAN_END  = 2'd1,
    KIND_COUNT_ERR = 2'd2,
    KIND_OVERRUN   = 2'd3
  } kind_e;

  // Configuration register group.
  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  ok_code;
    logic [7:0]  abort_code;
    logic [23:0] max_points;
  } sfd_cfg_t;

  // A received byte with its classification flags.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rearm;
    logic       is_pre;
    logic       is_hdr;
    logic       is_esc;
    logic       is_ok;
    logic       is_abort;
    logic       is_last;
  } sfd_item_t;

  // One result item.
  typedef struct packed {
    kind_e        kind;
    logic [31:0]  point_value;
    logic [15:0]  scan_number;
    logic [23:0]  points_seen;
    logic [23:0]  points_expected;
    logic         complete;
    logic         misaligned;
    logic         count_mismatch;
    logic         all_done;
  } sfd_result_t;

endpackage

### src/scan_frame_deframer_top.sv
// Scan frame deframer top level: a result passes through the front register, the
// queue and the result register before it is offered; one byte per cycle is
// sustained when the output side keeps up. Reset clears all frame state and loads
// the configuration defaults; no clearing pass is needed.
// Holds the configuration registers; depends on sfd_pkg and all sfd modules.
`timescale 1ns / 1ps

module scan_frame_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               rearm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] point_value_o,
  output logic [15:0]        scan_number_o,
  output logic [23:0]        points_seen_o,
  output logic [23:0]        points_expected_o,
  output logic               complete_o,
  output logic               misaligned_o,
  output logic               count_mismatch_o,
  output logic               all_done_o
);
  import sfd_pkg::*;

  sfd_cfg_t    cfg_q, cfg_d;
  sfd_item_t   front_item, queue_item;
  logic        push, full, pop, empty;
  sfd_result_t res;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_BYTE: cfg_d.header_byte = cfg_data_i[7:0];
        CFG_ESCAPE_BYTE: cfg_d.escape_byte = cfg_data_i[7:0];
        CFG_OK_CODE:     cfg_d.ok_code     = cfg_data_i[7:0];
        CFG_ABORT_CODE:  cfg_d.abort_code  = cfg_data_i[7:0];
        CFG_MAX_POINTS:  cfg_d.max_points  = cfg_data_i;
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= RST_HEADER_BYTE;
      cfg_q.escape_byte <= RST_ESCAPE_BYTE;
      cfg_q.ok_code     <= RST_OK_CODE;
      cfg_q.abort_code  <= RST_ABORT_CODE;
      cfg_q.max_points  <= RST_MAX_POINTS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front stage: input transfer and byte classification.
  sfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .rearm_i    (rearm_i),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  // Item queue between the two sides.
  sfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (queue_item)
  );

  // Back part: frame decoding and result register.
  sfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_points_i (cfg_q.max_points),
    .empty_i      (empty),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  // Result fields to ports.
  assign kind_o            = res.kind;
  assign point_value_o     = res.point_value;
  assign scan_number_o     = res.scan_number;
  assign points_seen_o     = res.points_seen;
  assign points_expected_o = res.points_expected;
  assign complete_o        = res.complete;
  assign misaligned_o      = res.misaligned;
  assign count_mismatch_o  = res.count_mismatch;
  assign all_done_o        = res.all_done;

endmodule

### src/sfd_front.sv
// Front stage of the deframer: takes each input transfer and classifies the byte.
// Depends on sfd_pkg; feeds the item queue.
`timescale 1ns / 1ps

module sfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfd_pkg::sfd_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              rearm_i,
  output logic              push_o,
  output sfd_pkg::sfd_item_t item_o,
  input  logic              full_i
);
  import sfd_pkg::*;

  logic      valid_q, valid_d;
  sfd_item_t item_q, item_d;
  logic      accept;
  logic      push_ok;

  // Stage is free when empty or when its item moves into the queue this cycle.
  assign push_ok    = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = push_ok;
  assign item_o     = item_q;

  // Classify the byte against the fixed and configured codes.
  always_comb begin
    item_d          = item_q;
    item_d.rx_byte  = rx_byte_i;
    item_d.rearm    = rearm_i;
    item_d.is_pre   = (rx_byte_i == PREAMBLE_BYTE);
    item_d.is_hdr   = (rx_byte_i == cfg_i.header_byte);
    item_d.is_esc   = (rx_byte_i == cfg_i.escape_byte);
    item_d.is_ok    = (rx_byte_i == cfg_i.ok_code);
    item_d.is_abort = (rx_byte_i == cfg_i.abort_code);
    item_d.is_last  = (rx_byte_i == LAST_MARK);
  end

  // Stage occupancy.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ok) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

### src/sfd_fifo.sv
// Short queue of classified items between the front stage and the deframer.
// Depends on sfd_pkg for the item type.
`timescale 1ns / 1ps

module sfd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfd_pkg::sfd_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sfd_pkg::sfd_item_t data_o
);
  import sfd_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  sfd_item_t       mem_q [DEPTH];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/sfd_back.sv
// Back part of the deframer: frame state machine, hold line, word assembly
// and the result register. Depends on sfd_pkg; drains the item queue.
`timescale 1ns / 1ps

module sfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [23:0]          max_points_i,
  input  logic                 empty_i,
  input  sfd_pkg::sfd_item_t   item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfd_pkg::sfd_result_t res_o
);
  import sfd_pkg::*;

  localparam int unsigned HdrStore = HEADER_BYTES - 1;
  localparam logic [2:0] LastHdrIdx = 3'(HEADER_BYTES - 1);
  localparam logic [2:0] HoldFull   = 3'(HOLD_DEPTH);

  mode_e        mode_q, mode_d;
  logic         prev_pre_q, prev_pre_d;
  logic [2:0]   hdr_idx_q, hdr_idx_d;
  logic [7:0]   hdr_q [HdrStore];
  logic [7:0]   hdr_d [HdrStore];
  logic [23:0]  exp_q, exp_d;
  logic [15:0]  scan_q, scan_d;
  logic         final_q, final_d;
  logic [2:0]   esc_run_q, esc_run_d;
  logic [7:0]   hold_q [HOLD_DEPTH];
  logic [7:0]   hold_d [HOLD_DEPTH];
  logic [2:0]   hold_cnt_q, hold_cnt_d;
  logic [26:0]  byte_tot_q, byte_tot_d;
  logic [23:0]  word_q, word_d;
  logic [1:0]   phase_q, phase_d;
  logic [23:0]  pt_q, pt_d;

  logic         out_valid_q, out_valid_d;
  sfd_result_t  res_q, res_d;
  logic         res_hit;
  logic         take;

  // Helper values for header, trailer and overrun decisions.
  logic [23:0]  new_exp;
  logic [26:0]  overrun_lim;
  logic [24:0]  kept_words;
  logic         is_ok_code;
  logic [7:0]   leaving;

  assign take        = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = take;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign new_exp     = {hdr_q[2], hdr_q[1], hdr_q[0]};
  assign overrun_lim = {1'b0, exp_q, 2'b00} + 27'd8;
  assign kept_words  = byte_tot_q[26:2] - 25'd1;
  assign is_ok_code  = item_i.is_ok;
  assign leaving     = hold_q[0];

  // Frame state machine and data path for one item.
  always_comb begin
    mode_d     = mode_q;
    prev_pre_d = prev_pre_q;
    hdr_idx_d  = hdr_idx_q;
    hdr_d      = hdr_q;
    exp_d      = exp_q;
    scan_d     = scan_q;
    final_d    = final_q;
    esc_run_d  = esc_run_q;
    hold_d     = hold_q;
    hold_cnt_d = hold_cnt_q;
    byte_tot_d = byte_tot_q;
    word_d     = word_q;
    phase_d    = phase_q;
    pt_d       = pt_q;
    res_hit    = 1'b0;
    res_d      = '0;

    if (take) begin
      prev_pre_d = item_i.is_pre;
      if (item_i.rearm) begin
        // Rearm clears the whole frame state; the byte is dropped.
        mode_d     = MODE_HUNT;
        prev_pre_d = 1'b0;
        hdr_idx_d  = '0;
        exp_d      = '0;
        scan_d     = '0;
        final_d    = 1'b0;
        esc_run_d  = '0;
        hold_cnt_d = '0;
        byte_tot_d = '0;
        word_d     = '0;
        phase_d    = '0;
        pt_d       = '0;
      end else begin
        unique case (mode_q)
          MODE_HUNT: begin
            if (prev_pre_q && item_i.is_hdr) begin
              mode_d    = MODE_HEADER;
              hdr_idx_d = '0;
            end
          end
          MODE_HEADER: begin
            if (hdr_idx_q == LastHdrIdx) begin
              // Last header byte: latch the header and check the count.
              exp_d      = new_exp;
              scan_d     = {hdr_q[4], hdr_q[3]};
              final_d    = item_i.is_last;
              esc_run_d  = '0;
              hold_cnt_d = '0;
              byte_tot_d = '0;
              word_d     = '0;
              phase_d    = '0;
              pt_d       = '0;
              hdr_idx_d  = '0;
              if ((new_exp == '0) || (new_exp > max_points_i)) begin
                res_hit    = 1'b1;
                res_d.kind = KIND_COUNT_ERR;
                mode_d     = MODE_HUNT;
              end else begin
                mode_d = MODE_DATA;
              end
            end else begin
              hdr_d[hdr_idx_q] = item_i.rx_byte;
              hdr_idx_d        = hdr_idx_q + 3'd1;
            end
          end
          MODE_DATA: begin
            if ((esc_run_q >= HoldFull) && (item_i.is_ok || item_i.is_abort)) begin
              // Trailer: the held escape bytes are dropped.
              res_hit              = 1'b1;
              res_d.kind           = KIND_SCAN_END;
              res_d.points_seen    = pt_q;
              res_d.complete       = is_ok_code;
              res_d.misaligned     = (byte_tot_q[1:0] != 2'b00);
              res_d.count_mismatch = is_ok_code && (kept_words != {1'b0, exp_q});
              res_d.all_done       = final_q || !is_ok_code;
              mode_d               = (final_q || !is_ok_code) ? MODE_DONE : MODE_HUNT;
              esc_run_d            = '0;
              hold_cnt_d           = '0;
              byte_tot_d           = '0;
              word_d               = '0;
              phase_d              = '0;
              pt_d                 = '0;
            end else begin
              // Shift the byte into the hold line; the oldest leaves when full.
              hold_d[0] = hold_q[1];
              hold_d[1] = hold_q[2];
              hold_d[2] = hold_q[3];
              hold_d[3] = item_i.rx_byte;
              if (hold_cnt_q != HoldFull) begin
                hold_cnt_d = hold_cnt_q + 3'd1;
              end
              byte_tot_d = byte_tot_q + 27'd1;
              if (item_i.is_esc) begin
                if (esc_run_q < HoldFull) begin
                  esc_run_d = esc_run_q + 3'd1;
                end
              end else begin
                esc_run_d = '0;
              end
              // Little-endian word assembly from the leaving byte.
              if (hold_cnt_q == HoldFull) begin
                if (phase_q == 2'd3) begin
                  if (pt_q != 24'hFF_FFFF) begin
                    pt_d = pt_q + 24'd1;
                  end
                  res_hit           = 1'b1;
                  res_d.kind        = KIND_POINT;
                  res_d.point_value = {leaving, word_q};
                  res_d.points_seen = pt_d;
                  word_d            = '0;
                  phase_d           = '0;
                end else begin
                  unique case (phase_q)
                    2'd0:    word_d[7:0]   = leaving;
                    2'd1:    word_d[15:8]  = leaving;
                    default: word_d[23:16] = leaving;
                  endcase
                  phase_d = phase_q + 2'd1;
                end
              end
              // Overrun replaces any point result of the same byte.
              if (byte_tot_q >= overrun_lim) begin
                res_hit           = 1'b1;
                res_d             = '0;
                res_d.kind        = KIND_OVERRUN;
                res_d.points_seen = pt_d;
                mode_d            = MODE_HUNT;
                esc_run_d         = '0;
                hold_cnt_d        = '0;
                byte_tot_d        = '0;
                word_d            = '0;
                phase_d           = '0;
                pt_d              = '0;
              end
            end
          end
          default: begin
            // Done: bytes are ignored until rearm.
          end
        endcase
      end
    end
    res_d.scan_number     = scan_d;
    res_d.points_expected = exp_d;
  end

  // Result register: loads on each processed item, empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = res_hit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_HUNT;
      prev_pre_q  <= 1'b0;
      hdr_idx_q   <= '0;
      exp_q       <= '0;
      scan_q      <= '0;
      final_q     <= 1'b0;
      esc_run_q   <= '0;
      hold_cnt_q  <= '0;
      byte_tot_q  <= '0;
      word_q      <= '0;
      phase_q     <= '0;
      pt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      prev_pre_q  <= prev_pre_d;
      hdr_idx_q   <= hdr_idx_d;
      exp_q       <= exp_d;
      scan_q      <= scan_d;
      final_q     <= final_d;
      esc_run_q   <= esc_run_d;
      hold_cnt_q  <= hold_cnt_d;
      byte_tot_q  <= byte_tot_d;
      word_q      <= word_d;
      phase_q     <= phase_d;
      pt_q        <= pt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: header bytes, hold line and result.
  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    hold_q <= hold_d;
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

### tb/sfd_result_checker.sv
// Result checker for the scan frame deframer: follows the register, byte and result
// transfers, predicts each result from the accepted bytes and compares it field by field.
// Depends on sfd_pkg for the register indexes, modes, result kinds and framing constants.
`timescale 1ns / 1ps

module sfd_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rearm_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] point_value_i,
  input  logic [15:0] scan_number_i,
  input  logic [23:0] points_seen_i,
  input  logic [23:0] points_expected_i,
  input  logic        complete_i,
  input  logic        misaligned_i,
  input  logic        count_mismatch_i,
  input  logic        all_done_i,
  output int          fail_count_o,
  output int          awaited_o
);

  import sfd_pkg::*;

  // Local copy of the configuration registers.
  logic [7:0]  hdr_byte;
  logic [7:0]  esc_byte;
  logic [7:0]  ok_byte;
  logic [7:0]  abort_byte;
  logic [23:0] max_count;

  // Deframer state as the predictor tracks it.
  mode_e       mode;
  logic [7:0]  last_byte;
  int unsigned hdr_pos;
  logic [7:0]  hdr_buf [HEADER_BYTES];
  logic [23:0] hdr_points;
  logic [15:0] scan_id;
  logic        final_scan;
  int unsigned esc_run;
  logic [7:0]  hold_buf [HOLD_DEPTH];
  int unsigned hold_fill;
  int unsigned data_bytes;
  logic [23:0] word_acc;
  int unsigned word_pos;
  logic [23:0] point_count;

  // Results predicted but not yet seen at the output.
  sfd_result_t awaited_results [$];
  sfd_result_t oldest;

  function automatic void clear_scan_data();
    esc_run     = 0;
    hold_fill   = 0;
    data_bytes  = 0;
    word_acc    = '0;
    word_pos    = 0;
    point_count = '0;
  endfunction

  function automatic void clear_deframer();
    mode       = MODE_HUNT;
    last_byte  = '0;
    hdr_pos    = 0;
    hdr_points = '0;
    scan_id    = '0;
    final_scan = 1'b0;
    clear_scan_data();
  endfunction

  function automatic void await_result(kind_e kind, logic [31:0] value, logic [23:0] seen,
                                       logic cpl, logic mis, logic mm, logic ad);
    sfd_result_t r;
    r.kind            = kind;
    r.point_value     = value;
    r.scan_number     = scan_id;
    r.points_seen     = seen;
    r.points_expected = hdr_points;
    r.complete        = cpl;
    r.misaligned      = mis;
    r.count_mismatch  = mm;
    r.all_done        = ad;
    awaited_results.push_back(r);
  endfunction

  // Advance the deframer by one accepted byte and queue the result it causes, if any.
  function automatic void deframe_byte(logic [7:0] c, logic rearm);
    logic [7:0]  leaving;
    logic        shifted;
    logic        word_done;
    logic [31:0] word_value;
    logic        cpl, mis, mm, ad;
    int unsigned kept;
    int unsigned limit;
    if (rearm) begin
      clear_deframer();
    end else begin
      case (mode)
        MODE_HUNT: begin
          if (last_byte == PREAMBLE_BYTE && c == hdr_byte) begin
            mode    = MODE_HEADER;
            hdr_pos = 0;
          end
        end
        MODE_HEADER: begin
          hdr_buf[hdr_pos] = c;
          hdr_pos++;
          if (hdr_pos >= HEADER_BYTES) begin
            hdr_points = {hdr_buf[2], hdr_buf[1], hdr_buf[0]};
            scan_id    = {hdr_buf[4], hdr_buf[3]};
            final_scan = (hdr_buf[5] == LAST_MARK);
            clear_scan_data();
            hdr_pos = 0;
            if (hdr_points == 24'd0 || hdr_points > max_count) begin
              await_result(KIND_COUNT_ERR, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
              mode = MODE_HUNT;
            end else begin
              mode = MODE_DATA;
            end
          end
        end
        MODE_DATA: begin
          if (esc_run >= 4 && (c == ok_byte || c == abort_byte)) begin
            // Trailer: the four held escape bytes do not count as data.
            kept = data_bytes - HOLD_DEPTH;
            cpl  = (c == ok_byte);
            mis  = (kept[1:0] != 2'd0);
            mm   = cpl && ((kept >> 2) != hdr_points);
            ad   = final_scan || !cpl;
            await_result(KIND_SCAN_END, '0, point_count, cpl, mis, mm, ad);
            clear_scan_data();
            mode = ad ? MODE_DONE : MODE_HUNT;
          end else begin
            shifted   = 1'b0;
            word_done = 1'b0;
            leaving   = '0;
            word_value = '0;
            if (hold_fill >= HOLD_DEPTH) begin
              leaving     = hold_buf[0];
              shifted     = 1'b1;
              hold_buf[0] = hold_buf[1];
              hold_buf[1] = hold_buf[2];
              hold_buf[2] = hold_buf[3];
              hold_buf[3] = c;
            end else begin
              hold_buf[hold_fill] = c;
              hold_fill++;
            end
            data_bytes = (data_bytes + 1) & 32'h07FF_FFFF;
            if (c == esc_byte) begin
              if (esc_run < 4) esc_run++;
            end else begin
              esc_run = 0;
            end
            // Bytes leaving the hold line build a little-endian word.
            if (shifted) begin
              if (word_pos == 3) begin
                if (point_count != 24'hFF_FFFF) point_count++;
                word_value = {leaving, word_acc};
                word_done  = 1'b1;
                word_acc   = '0;
                word_pos   = 0;
              end else begin
                word_acc[8*word_pos +: 8] = leaving;
                word_pos++;
              end
            end
            limit = hdr_points;
            limit = limit * 4 + 8;
            // An overrun result takes the place of a point finished by the same byte.
            if (data_bytes > limit) begin
              await_result(KIND_OVERRUN, '0, point_count, 1'b0, 1'b0, 1'b0, 1'b0);
              clear_scan_data();
              mode = MODE_HUNT;
            end else if (word_done) begin
              await_result(KIND_POINT, word_value, point_count, 1'b0, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        MODE_DONE: ;
      endcase
      last_byte = c;
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  // Compare, update registers and predict at every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_byte   = RST_HEADER_BYTE;
      esc_byte   = RST_ESCAPE_BYTE;
      ok_byte    = RST_OK_CODE;
      abort_byte = RST_ABORT_CODE;
      max_count  = RST_MAX_POINTS;
      clear_deframer();
      awaited_results.delete();
      fail_count_o = 0;
      awaited_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result of kind %0d with no prediction waiting", kind_i);
          fail_count_o++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("kind", oldest.kind, kind_i);
          compare_field("point_value", oldest.point_value, point_value_i);
          compare_field("scan_number", oldest.scan_number, scan_number_i);
          compare_field("points_seen", oldest.points_seen, points_seen_i);
          compare_field("points_expected", oldest.points_expected, points_expected_i);
          compare_field("complete", oldest.complete, complete_i);
          compare_field("misaligned", oldest.misaligned, misaligned_i);
          compare_field("count_mismatch", oldest.count_mismatch, count_mismatch_i);
          compare_field("all_done", oldest.all_done, all_done_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HEADER_BYTE: hdr_byte   = cfg_data_i[7:0];
          CFG_ESCAPE_BYTE: esc_byte   = cfg_data_i[7:0];
          CFG_OK_CODE:     ok_byte    = cfg_data_i[7:0];
          CFG_ABORT_CODE:  abort_byte = cfg_data_i[7:0];
          CFG_MAX_POINTS:  max_count  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        deframe_byte(rx_byte_i, rearm_i);
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the scan frame deframer testbench: clock, reset, register setup and byte stimulus.
// Depends on sfd_pkg, scan_frame_deframer_top and sfd_result_checker.
`timescale 1ns / 1ps

module testbench;

  import sfd_pkg::*;

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum {END_OK, END_ABORT, END_NONE} frame_end_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = '0;
  logic        rearm     = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;

  logic [1:0]         kind;
  logic signed [31:0] point_value;
  logic [15:0]        scan_number;
  logic [23:0]        points_seen;
  logic [23:0]        points_expected;
  logic               complete;
  logic               misaligned;
  logic               count_mismatch;
  logic               all_done;

  int fail_count;
  int awaited_count;

  // Stimulus controls and the register values currently loaded.
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  bit          hold_off_req  = 1'b0;
  bit          counting      = 1'b1;
  int unsigned items_sent    = 0;
  logic [7:0]  hdr_setting   = RST_HEADER_BYTE;
  logic [7:0]  esc_setting   = RST_ESCAPE_BYTE;
  logic [7:0]  ok_setting    = RST_OK_CODE;
  logic [7:0]  abort_setting = RST_ABORT_CODE;
  logic [23:0] max_setting   = RST_MAX_POINTS;

  scan_frame_deframer_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .rearm_i          (rearm),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .point_value_o    (point_value),
    .scan_number_o    (scan_number),
    .points_seen_o    (points_seen),
    .points_expected_o(points_expected),
    .complete_o       (complete),
    .misaligned_o     (misaligned),
    .count_mismatch_o (count_mismatch),
    .all_done_o       (all_done)
  );

  sfd_result_checker frame_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .rx_byte_i        (rx_byte),
    .rearm_i          (rearm),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .point_value_i    (point_value),
    .scan_number_i    (scan_number),
    .points_seen_i    (points_seen),
    .points_expected_i(points_expected),
    .complete_i       (complete),
    .misaligned_i     (misaligned),
    .count_mismatch_i (count_mismatch),
    .all_done_i       (all_done),
    .fail_count_o     (fail_count),
    .awaited_o        (awaited_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one byte after random idle cycles and wait for its transfer.
  task automatic transfer_byte(input logic [7:0] b, input logic r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    rearm    <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counting) items_sent++;
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load all registers once no result is outstanding and the pipeline has drained.
  task automatic load_settings(input logic [7:0] hb, eb, okc, abc, input logic [23:0] mp);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaited_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_HEADER_BYTE, {16'd0, hb});
    write_reg(CFG_ESCAPE_BYTE, {16'd0, eb});
    write_reg(CFG_OK_CODE, {16'd0, okc});
    write_reg(CFG_ABORT_CODE, {16'd0, abc});
    write_reg(CFG_MAX_POINTS, mp);
    cfg_valid <= 1'b0;
    hdr_setting   = hb;
    esc_setting   = eb;
    ok_setting    = okc;
    abort_setting = abc;
    max_setting   = mp;
  endtask

  function automatic logic [7:0] data_byte();
    return ($urandom_range(15) == 0) ? esc_setting : 8'($urandom);
  endfunction

  function automatic int unsigned pick_count(int unsigned cap);
    return $urandom_range((max_setting < cap) ? max_setting : cap, 1);
  endfunction

  // Preamble pair, header, data bytes and an optional trailer.
  task automatic send_frame(input logic [23:0] count, input logic [15:0] scan, input bit last,
                            input int unsigned data_len, input frame_end_e ending);
    int unsigned sent;
    logic [7:0]  other;
    transfer_byte(PREAMBLE_BYTE, 1'b0);
    transfer_byte(hdr_setting, 1'b0);
    transfer_byte(count[7:0], 1'b0);
    transfer_byte(count[15:8], 1'b0);
    transfer_byte(count[23:16], 1'b0);
    transfer_byte(scan[7:0], 1'b0);
    transfer_byte(scan[15:8], 1'b0);
    transfer_byte(last ? LAST_MARK : 8'($urandom_range(254)), 1'b0);
    sent = 0;
    while (sent < data_len) begin
      // An escape run that no trailer code follows stays in the data.
      if (data_len - sent >= 5 && $urandom_range(39) == 0 &&
          esc_setting != ok_setting && esc_setting != abort_setting) begin
        repeat (4) transfer_byte(esc_setting, 1'b0);
        do other = 8'($urandom); while (other == ok_setting || other == abort_setting);
        transfer_byte(other, 1'b0);
        sent += 5;
      end else begin
        transfer_byte(data_byte(), 1'b0);
        sent++;
      end
    end
    if (ending != END_NONE) begin
      repeat (4) transfer_byte(esc_setting, 1'b0);
      transfer_byte((ending == END_OK) ? ok_setting : abort_setting, 1'b0);
    end
  endtask

  // One random frame: mostly well formed, the rest bad counts, overruns and cut-offs.
  task automatic random_frame();
    int unsigned pick;
    int unsigned count;
    int unsigned len;
    bit          last;
    frame_end_e  ending;
    pick = $urandom_range(99);
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(5, 1))
        transfer_byte(($urandom_range(3) == 0) ? PREAMBLE_BYTE : 8'($urandom), 1'b0);
    end
    if (pick < 10) begin
      if (max_setting == 24'hFF_FFFF || $urandom_range(1) == 0) count = 0;
      else if ($urandom_range(1) == 0) count = max_setting + 1;
      else count = $urandom_range(24'hFF_FFFF, max_setting + 1);
      send_frame(24'(count), 16'($urandom), 1'($urandom_range(1)), 0, END_NONE);
    end else if (pick < 18) begin
      // Data past four bytes per point plus the trailer allowance.
      count = pick_count(4);
      send_frame(24'(count), 16'($urandom), 1'b0, count * 4 + $urandom_range(12, 9),
                 END_NONE);
    end else if (pick < 26) begin
      // Frame cut short by a rearm.
      send_frame(24'(pick_count(8)), 16'($urandom), 1'($urandom_range(1)),
                 $urandom_range(12), END_NONE);
      transfer_byte(8'($urandom), 1'b1);
    end else begin
      count = ($urandom_range(9) == 0) ? pick_count(48) : pick_count(6);
      len   = count * 4;
      case ($urandom_range(6))
        0: len -= $urandom_range((len < 7) ? len : 7);
        1: len += $urandom_range(4, 1);
        default: ;
      endcase
      last   = ($urandom_range(6) == 0);
      ending = ($urandom_range(5) == 0) ? END_ABORT : END_OK;
      send_frame(24'(count), 16'($urandom), last, len, ending);
      // After the command ends, bytes are ignored until a rearm.
      if (last || ending == END_ABORT) begin
        counting = 1'b0;
        if ($urandom_range(1) == 0) begin
          transfer_byte(PREAMBLE_BYTE, 1'b0);
          transfer_byte(hdr_setting, 1'b0);
        end
        repeat ($urandom_range(2)) transfer_byte(8'($urandom), 1'b0);
        counting = 1'b1;
        transfer_byte(8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    logic [7:0] first_scan [17];
    logic [7:0] over_limit [8];
    first_scan = '{
      PREAMBLE_BYTE, RST_HEADER_BYTE, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, LAST_MARK,
      8'h00, 8'h00, 8'h00, 8'h80,
      RST_ESCAPE_BYTE, RST_ESCAPE_BYTE, RST_ESCAPE_BYTE, RST_ESCAPE_BYTE, RST_OK_CODE
    };
    over_limit = '{
      PREAMBLE_BYTE, RST_HEADER_BYTE, 8'hD1, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00
    };
    tx_idle_pct = 17;
    rx_idle_pct = 75;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Last scan of one point at the most negative value, ended by an OK trailer.
    foreach (first_scan[i]) transfer_byte(first_scan[i], 1'b0);
    // A preamble pair is ignored once done; rearm returns to the hunt.
    transfer_byte(PREAMBLE_BYTE, 1'b0);
    transfer_byte(RST_HEADER_BYTE, 1'b0);
    transfer_byte(8'hFF, 1'b1);
    // Header count one above the default limit.
    foreach (over_limit[i]) transfer_byte(over_limit[i], 1'b0);

    // Smallest point limit, codes at the byte extremes.
    load_settings(8'hFF, 8'h00, 8'hFF, 8'h01, 24'd1);
    while (items_sent < 430) random_frame();

    tx_idle_pct = 75;
    rx_idle_pct = 17;
    load_settings(8'h00, 8'hFF, 8'h00, 8'hFE, 24'hFF_FFFF);
    while (items_sent < 830) random_frame();

    // Long receiver hold-off while a long scan streams in.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_settings(RST_HEADER_BYTE, RST_ESCAPE_BYTE, RST_OK_CODE, RST_ABORT_CODE,
                  RST_MAX_POINTS);
    hold_off_req = 1'b1;
    send_frame(24'd40, 16'h1234, 1'b0, 160, END_OK);
    while (items_sent < 1230) random_frame();

    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  24'($urandom_range(300, 1)));
    while (items_sent < 1630) random_frame();

    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaited_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/sfd_pkg.sv
src/sfd_front.sv
src/sfd_fifo.sv
src/sfd_back.sv
src/scan_frame_deframer_top.sv
tb/sfd_result_checker.sv
tb/testbench.sv
